// ----- hdl/sha1_message_digest_core_defines.svh -----
// ----------------------------------------------------------------------------
// SHA-1 digest core assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SHA1MD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sha1md assertion failed");
`define SHA1MD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sha1md forbidden condition");
`else
`define SHA1MD_ASSERT(lbl, prop)
`define SHA1MD_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- hdl/sha1md_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 digest core package
// Shared types and constants for the front queue and the hash engine.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [4:0][31:0] H_INIT = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic       last;
    logic       valid;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ----- hdl/sha1md_front.sv -----
// ----------------------------------------------------------------------------
// SHA-1 front queue
// Accepts input items, drops items that carry neither a byte nor an end
// mark, and queues the rest for the engine.
// ----------------------------------------------------------------------------
`include "sha1_message_digest_core_defines.svh"

module sha1md_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sha1md_pkg::item_t   in_item_i,
  output sha1md_pkg::head_t   head_o,
  input  logic                pop_i
);
  import sha1md_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;
  logic               push, pop;

  assign in_ready_o = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign push = in_valid_i && in_ready_o && (in_item_i.valid || in_item_i.last);
  assign pop  = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `SHA1MD_ASSERT(a_count_bound, count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
  `SHA1MD_ASSERT_NEVER(a_pop_empty, pop_i && (count_q == '0))
  `SHA1MD_ASSERT_NEVER(a_push_full, push && (count_q == (FIFO_AW+1)'(FIFO_DEPTH)))

endmodule

// ----- hdl/sha1md_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Packs bytes into the block shift register, pads at message end, runs one
// compression round per cycle and emits the five digest words.
// ----------------------------------------------------------------------------
`include "sha1_message_digest_core_defines.svh"

module sha1md_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1md_pkg::head_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       out_word_o,
  output logic [2:0]        out_index_o,
  output logic              out_last_o
);
  import sha1md_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } eng_state_e;

  typedef enum logic [4:0] {
    PAD_IDLE = 5'b00001,
    PAD_MARK = 5'b00010,
    PAD_ZERO = 5'b00100,
    PAD_LEN  = 5'b01000,
    PAD_DONE = 5'b10000
  } pad_e;

  eng_state_e       state_q, state_d;
  pad_e             pad_q, pad_d;
  logic [5:0]       pos_q, pos_d;
  logic [63:0]      bits_q, bits_d;
  logic [6:0]       round_q, round_d;
  logic [511:0]     blk_q, blk_d;
  logic [4:0][31:0] h_q, h_d;
  logic [4:0][31:0] wk_q, wk_d;
  logic [2:0]       sel_q, sel_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_word_q, out_word_d;
  logic [2:0]       out_index_q, out_index_d;

  logic             wr_en;
  logic [7:0]       wr_byte;
  logic [31:0]      a, b, c, d, e, f, k, w_cur, w_mix, temp;

  assign a     = wk_q[0];
  assign b     = wk_q[1];
  assign c     = wk_q[2];
  assign d     = wk_q[3];
  assign e     = wk_q[4];
  assign w_cur = blk_q[511:480];
  assign w_mix = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];

  always_comb begin
    if (round_q inside {[7'd0:7'd19]}) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round_q inside {[7'd20:7'd39]}) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round_q inside {[7'd40:7'd59]}) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    temp = {a[26:0], a[31:27]} + f + e + k + w_cur;
  end

  always_comb begin
    state_d     = state_q;
    pad_d       = pad_q;
    pos_d       = pos_q;
    bits_d      = bits_q;
    round_d     = round_q;
    blk_d       = blk_q;
    h_d         = h_q;
    wk_d        = wk_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_index_d = out_index_q;
    pop_o       = 1'b0;
    wr_en       = 1'b0;
    wr_byte     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.item.valid) begin
            wr_en   = 1'b1;
            wr_byte = head_i.item.data;
            bits_d  = bits_q + 64'd8;
          end
          if (head_i.item.last) begin
            pad_d   = PAD_MARK;
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        case (pad_q)
          PAD_MARK: begin
            wr_en   = 1'b1;
            wr_byte = PAD_BYTE;
            pad_d   = PAD_ZERO;
          end
          PAD_ZERO: begin
            if (pos_q == 6'd56) begin
              pad_d = PAD_LEN;
            end else begin
              wr_en = 1'b1;
            end
          end
          PAD_LEN: begin
            wr_en   = 1'b1;
            wr_byte = bits_q[63:56];
            bits_d  = {bits_q[55:0], 8'h00};
            if (pos_q == 6'd63) begin
              pad_d = PAD_DONE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ROUND: begin
        wk_d[0] = temp;
        wk_d[1] = a;
        wk_d[2] = {b[1:0], b[31:2]};
        wk_d[3] = c;
        wk_d[4] = d;
        blk_d   = {blk_q[479:0], w_mix[30:0], w_mix[31]};
        round_d = round_q + 7'd1;
        if (round_q == 7'd79) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        for (int j = 0; j < 5; j++) begin
          h_d[j] = h_q[j] + wk_q[j];
        end
        if (pad_q == PAD_DONE) begin
          state_d = S_OUT;
          sel_d   = '0;
        end else if (pad_q == PAD_IDLE) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_PAD;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_word_d  = h_q[sel_q];
          out_index_d = sel_q;
          sel_d       = sel_q + 3'd1;
          if (sel_q == 3'd4) begin
            h_d     = H_INIT;
            bits_d  = '0;
            pos_d   = '0;
            pad_d   = PAD_IDLE;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (wr_en) begin
      blk_d = {blk_q[503:0], wr_byte};
      pos_d = pos_q + 6'd1;
      if (pos_q == 6'd63) begin
        state_d = S_ROUND;
        round_d = '0;
        wk_d    = h_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    wk_q  <= wk_d;
    out_word_q  <= out_word_d;
    out_index_q <= out_index_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pad_q       <= PAD_IDLE;
      pos_q       <= '0;
      bits_q      <= '0;
      round_q     <= '0;
      h_q         <= H_INIT;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pad_q       <= pad_d;
      pos_q       <= pos_d;
      bits_q      <= bits_d;
      round_q     <= round_d;
      h_q         <= h_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = (out_index_q == 3'd4);

  `SHA1MD_ASSERT(a_round_range, (state_q == S_ROUND) |-> (round_q < 7'd80))
  `SHA1MD_ASSERT(a_len_tail, (state_q == S_PAD && pad_q == PAD_LEN) |-> (pos_q[5:3] == 3'b111))
  `SHA1MD_ASSERT(a_done_to_out, (state_q == S_ADD && pad_q == PAD_DONE) |=> (state_q == S_OUT))
  `SHA1MD_ASSERT_NEVER(a_out_index, out_valid_q && (out_index_q > 3'd4))

endmodule

// ----- hdl/sha1_message_digest_core.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Byte stream in, five 32-bit digest words out per message.
// ----------------------------------------------------------------------------
// Each input item carries one message byte (tuser[0] set) and/or an end mark
// (tlast); an item with neither is accepted and ignored. A four-entry queue
// takes items while the engine is busy. The engine takes one byte per cycle
// while idle; every 64th byte starts 80 rounds at one round per cycle plus
// the chaining add, during which it takes no bytes. An end mark adds 9 to 72
// padding bytes, one or two compressions, then five words h0..h4 through a
// registered output, after which the core is ready for the next message.
module sha1_message_digest_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] byte_valid
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o
);
  import sha1md_pkg::*;

  item_t in_item;
  head_t head;
  logic  pop;

  assign in_item.last  = s_axis_tlast_i;
  assign in_item.valid = s_axis_tuser_i[0];
  assign in_item.data  = s_axis_tdata_i;

  sha1md_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .head_o     (head),
    .pop_i      (pop)
  );

  sha1md_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (m_axis_tdata_o),
    .out_index_o (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// SHA-1 digest core testbench
// Streams messages into the core one byte per item, with end-only and ignored
// items mixed in, and checks every digest word against a SHA-1 predictor.
// Known digests (empty message, "abc") are checked as typed-in values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import sha1md_pkg::*;

  localparam int RST_CYCLES  = 8;
  localparam int IDLE_PCT    = 22;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 300;
  localparam int MAX_REPORTS = 10;
  localparam int N_DIR       = 13;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lst;
  } digest_word_t;

  typedef struct {
    logic [7:0]       data;
    bit               valid;
    bit               last;
    bit               typed;
    logic [4:0][31:0] h;
  } stim_row_t;

  localparam logic [4:0][31:0] NO_H = '0;
  localparam logic [4:0][31:0] EMPTY_H = {
    32'hafd80709, 32'h95601890, 32'h3255bfef, 32'h5e6b4b0d, 32'hda39a3ee
  };
  localparam logic [4:0][31:0] ABC_H = {
    32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571, 32'h4706816a, 32'ha9993e36
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;

  // predictor state
  logic [31:0] chain_h [5];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;
  digest_word_t digest_q [$];

  int unsigned errors;
  int unsigned items_in;
  int unsigned words_ok;
  int unsigned msgs;
  int unsigned longest;
  int unsigned stall_cnt = 0;

  stim_row_t dir_rows [N_DIR] = '{
    '{8'h3c, 1'b0, 1'b0, 1'b0, NO_H},     // ignored item after reset
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_H},  // empty message
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_H},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_H},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_H},    // "abc"
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_H},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_H},
    '{8'hff, 1'b0, 1'b1, 1'b0, NO_H},     // end-only item, data ignored
    '{8'h00, 1'b1, 1'b1, 1'b0, NO_H},
    '{8'hff, 1'b1, 1'b1, 1'b0, NO_H},
    '{8'h5a, 1'b1, 1'b0, 1'b0, NO_H},
    '{8'haa, 1'b0, 1'b0, 1'b0, NO_H},     // ignored item mid-message
    '{8'ha5, 1'b1, 1'b1, 1'b0, NO_H}
  };

  sha1_message_digest_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] rol(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void hash_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + k + w[r];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    blk_bytes[blk_fill] = v;
    blk_fill++;
    if (blk_fill == 64) begin
      hash_block();
      blk_fill = 0;
    end
  endfunction

  // one accepted item; pushes five digest words when it ends a message
  function automatic void predict_digest(input logic [7:0] d, input bit v, input bit l,
                                         input bit typed, input logic [4:0][31:0] typed_h);
    logic [63:0] len;
    digest_word_t dw;
    if (v) begin
      absorb_byte(d);
      msg_bits += 64'd8;
    end
    if (!l) return;
    len = msg_bits;
    absorb_byte(PAD_BYTE);
    while (blk_fill != 56) absorb_byte(8'h00);
    for (int j = 7; j >= 0; j--) absorb_byte(len[8*j +: 8]);
    for (int j = 0; j < 5; j++) begin
      dw.word = typed ? typed_h[j] : chain_h[j];
      dw.idx  = 3'(j);
      dw.lst  = (j == 4);
      digest_q.push_back(dw);
    end
    hash_restart();
  endfunction

  task automatic send_item(input logic [7:0] d, input bit v, input bit l,
                           input bit typed, input logic [4:0][31:0] typed_h);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= v;
    s_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_digest(d, v, l, typed, typed_h);
    if (v || l) items_in++;
  endtask

  task automatic send_message(input int unsigned len, input bit end_only);
    for (int unsigned i = 0; i <= len; i++) begin
      if ($urandom_range(0, 99) < 8)
        send_item(8'($urandom), 1'b0, 1'b0, 1'b0, NO_H);
      if (i < len)
        send_item(8'($urandom), 1'b1, !end_only && (i == len - 1), 1'b0, NO_H);
      else if (end_only)
        send_item(8'($urandom), 1'b0, 1'b1, 1'b0, NO_H);
    end
    msgs++;
    if (len > longest) longest = len;
  endtask

  // output side: check, then pick next tready
  initial begin
    digest_word_t exp_w;
    bit hold_taken;
    int unsigned hold_cnt;
    hold_taken = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_tready) begin
        if (digest_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected digest word %h idx %0d", $realtime,
                     m_axis_tdata_o, m_axis_tuser_o);
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w.word !== m_axis_tdata_o || exp_w.idx !== m_axis_tuser_o ||
              exp_w.lst !== m_axis_tlast_o) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: digest mismatch exp %h/%0d/%b got %h/%0d/%b", $realtime,
                       exp_w.word, exp_w.idx, exp_w.lst,
                       m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          end else begin
            words_ok++;
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_cnt = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else begin
        m_tready <= rst_ni && (calm || $urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("** sha1_message_digest_core: FAILED **");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned pick;
    int unsigned forced [3];
    forced = '{55, 56, 64};
    errors = 0; items_in = 0; words_ok = 0; msgs = 0; longest = 0;
    hash_restart();
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_DIR; r++) begin
      send_item(dir_rows[r].data, dir_rows[r].valid, dir_rows[r].last,
                dir_rows[r].typed, dir_rows[r].h);
      if (dir_rows[r].last) msgs++;
    end

    // padding boundaries: exact fit, spill into a second block, full block;
    // the full block is sent with the calm flag set, which turns off random idling
    for (int i = 0; i < 3; i++) begin
      calm <= (i == 2);
      send_message(forced[i], $urandom_range(0, 1));
    end
    calm <= 1'b0;

    while (items_in < 200 || msgs < 13) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(0, 8);
      else if (pick < 95) len = $urandom_range(9, 30);
      else len = $urandom_range(50, 70);
      if (msgs == 9) hold_req <= 1'b1;
      send_message(len, (len == 0) || ($urandom_range(0, 1) == 1));
    end
    s_tvalid <= 1'b0;
    calm <= 1'b0;

    while (digest_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    errors += digest_q.size();

    $display("run: %0d messages, %0d items, longest %0d bytes", msgs, items_in, longest);
    $display("     %0d digest words matched, %0d failures", words_ok, errors);
    if (errors == 0) begin
      $display("** sha1_message_digest_core: PASSED **");
    end else begin
      $display("** sha1_message_digest_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/sha1md_pkg.sv
hdl/sha1md_front.sv
hdl/sha1md_engine.sv
hdl/sha1_message_digest_core.sv
verif/tb.sv
